@@ rtl/lpct_pkg.sv @@
// Shared types and constants for the lidar point cluster block.
package lpct_pkg;
	localparam int CACHE_DEPTH_DEF = 256;
	localparam int SLOT_COUNT_DEF = 16;
	localparam logic [8:0] COUNT_MAX = 9'd511;
	localparam logic signed [15:0] ABSENT_X = -16'sd1000;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_LIFETIME = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_REPORT = 2'd2;
	localparam logic [1:0] REG_QUALITY = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [31:0] sample_time_ms;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0] rank;
		logic present;
		logic [8:0] quality;
		logic [31:0] seen_time_ms;
		logic signed [15:0] centre_x;
		logic signed [15:0] centre_y;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [15:0] data;
	} cfg_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLRSLOT, ST_REC_RD, ST_REC_CHK,
		ST_AGE_RD, ST_AGE_CHK, ST_SL_RD, ST_SL_CHK, ST_SL_MUL, ST_SL_CMP,
		ST_DIV, ST_SL_WR, ST_RK_RD, ST_RK_CHK, ST_OUT_RD, ST_OUT_SEND,
		ST_CLR_CMD
	} state_t;
endpackage

@@ rtl/lpct_if.sv @@
// Valid/ready channel interfaces for the lidar point cluster block.
interface lpct_in_if;
	logic valid;
	logic ready;
	lpct_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lpct_out_if;
	logic valid;
	logic ready;
	lpct_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lpct_cfg_if;
	logic valid;
	logic ready;
	lpct_pkg::cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/lpct_div.sv @@
// Iterative signed divider for the running mean, truncating toward zero.
module lpct_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [25:0] num,
	input logic [9:0] den,
	output logic done,
	output logic signed [15:0] quo
);
	logic [25:0] mag_q;
	logic [9:0] rem_q;
	logic [4:0] cnt_q;
	logic neg_q;
	logic busy_q;
	logic [10:0] trial;
	logic [25:0] qmag;

	assign trial = {rem_q, mag_q[25]};
	assign qmag = neg_q ? (~mag_q + 26'd1) : mag_q;
	assign quo = qmag[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd26;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[25];
			mag_q <= num[25] ? 26'(-num) : 26'(num);
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= 10'(trial - {1'b0, den});
				mag_q <= {mag_q[24:0], 1'b1};
			end else begin
				rem_q <= trial[9:0];
				mag_q <= {mag_q[24:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/lidar_point_cluster_top3_top.sv @@
// Top level of the lidar point cluster block: cache, slots and sequencer.
// Each command is accepted in ST_IDLE. Record: scans the cache entries for a free one.
// Update: ages each cache entry; for each live point walks the occupied slots, then starts
// a cluster or joins one (two divisions and a write-back); then ranks the slots and
// sends the results, subject to output stalls. Clear: empties every slot.
// One command at a time; after reset the cache and slots are cleared, and no items are taken.
module lidar_point_cluster_top3_top #(
	parameter int CACHE_DEPTH = lpct_pkg::CACHE_DEPTH_DEF,
	parameter int SLOT_COUNT = lpct_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	lpct_in_if.sink in_ch,
	lpct_out_if.source out_ch,
	lpct_cfg_if.sink cfg
);
	localparam int CW = $clog2(CACHE_DEPTH);
	localparam int SW = $clog2(SLOT_COUNT);

	lpct_pkg::state_t state_q, state_d;

	logic [15:0] lifetime_q;
	logic [11:0] radius_q;
	logic [1:0] report_q;
	logic [8:0] qthr_q;
	logic [31:0] now_q;

	logic [31:0] c_time [CACHE_DEPTH];
	logic [15:0] c_x [CACHE_DEPTH];
	logic [15:0] c_y [CACHE_DEPTH];
	logic [8:0] s_cnt [SLOT_COUNT];
	logic [31:0] s_time [SLOT_COUNT];
	logic [15:0] s_x [SLOT_COUNT];
	logic [15:0] s_y [SLOT_COUNT];

	logic [CW:0] ci_q;
	logic [SW:0] si_q;
	logic [31:0] crd_t_q;
	logic [15:0] crd_x_q, crd_y_q;
	logic [8:0] srd_n_q;
	logic [31:0] srd_t_q;
	logic signed [15:0] srd_x_q, srd_y_q;
	lpct_pkg::in_item_t cmd_q;
	logic signed [16:0] dx_q, dy_q;
	logic [33:0] sqx_q, sqy_q;
	logic [23:0] r2_q;
	logic [8:0] bn_q [3];
	logic [SW-1:0] bp_q [3];
	logic [1:0] k_q;
	logic div_y_q;
	logic signed [15:0] mx_q;
	logic div_start, div_done;
	logic signed [15:0] div_quo;
	logic signed [25:0] div_num;
	logic [9:0] div_den;
	lpct_pkg::out_item_t obuf_q;
	logic ovalid_q;
	logic clr_busy_q;

	logic [CW-1:0] ci;
	logic [SW-1:0] si;
	assign ci = ci_q[CW-1:0];
	assign si = si_q[SW-1:0];

	logic c_we, s_we;
	logic [31:0] age;
	assign age = now_q - crd_t_q;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == lpct_pkg::ST_IDLE) && !clr_busy_q;
	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= 16'd500;
			radius_q <= 12'd200;
			report_q <= 2'd3;
			qthr_q <= 9'd1;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				{1'b0, lpct_pkg::REG_LIFETIME}: lifetime_q <= cfg.data.data;
				{1'b0, lpct_pkg::REG_RADIUS}: radius_q <= cfg.data.data[11:0];
				{1'b0, lpct_pkg::REG_REPORT}: report_q <= cfg.data.data[1:0];
				{1'b0, lpct_pkg::REG_QUALITY}: qthr_q <= cfg.data.data[8:0];
				default: ;
			endcase
		end
	end

	// Cache memory: one port, read registered.
	logic [31:0] c_wt;
	logic [15:0] c_wx, c_wy;
	always_ff @(posedge clk) begin
		if (c_we) begin
			c_time[ci] <= c_wt;
			c_x[ci] <= c_wx;
			c_y[ci] <= c_wy;
		end
		crd_t_q <= c_time[ci];
		crd_x_q <= c_x[ci];
		crd_y_q <= c_y[ci];
	end

	// Slot memory: one port, read registered.
	logic [8:0] s_wn;
	logic [31:0] s_wt;
	logic [15:0] s_wx, s_wy;
	always_ff @(posedge clk) begin
		if (s_we) begin
			s_cnt[si] <= s_wn;
			s_time[si] <= s_wt;
			s_x[si] <= s_wx;
			s_y[si] <= s_wy;
		end
		srd_n_q <= s_cnt[si];
		srd_t_q <= s_time[si];
		srd_x_q <= s_x[si];
		srd_y_q <= s_y[si];
	end

	lpct_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);
	assign div_den = {1'b0, srd_n_q} + 10'd1;
	// The y division is started in the same cycle that the x division finishes.
	logic div_sel;
	assign div_sel = (state_q == lpct_pkg::ST_DIV) && (div_y_q || div_done);
	logic signed [25:0] prod;
	assign prod = $signed({1'b0, srd_n_q}) * (div_sel ? srd_y_q : srd_x_q);
	assign div_num = prod + 26'(div_sel ? $signed(crd_y_q) : $signed(crd_x_q));

	logic [34:0] d2;
	assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpct_pkg::ST_IDLE: if (acc) begin
				case (in_ch.data.command)
					lpct_pkg::CMD_RECORD: state_d = lpct_pkg::ST_REC_RD;
					lpct_pkg::CMD_UPDATE: state_d = lpct_pkg::ST_AGE_RD;
					lpct_pkg::CMD_CLEAR: state_d = lpct_pkg::ST_CLR_CMD;
					default: state_d = lpct_pkg::ST_IDLE;
				endcase
			end
			lpct_pkg::ST_CLRSLOT: state_d = lpct_pkg::ST_IDLE;
			lpct_pkg::ST_CLR_CMD:
				if (si_q == (SW+1)'(SLOT_COUNT - 1)) state_d = lpct_pkg::ST_IDLE;
			lpct_pkg::ST_REC_RD: state_d = lpct_pkg::ST_REC_CHK;
			lpct_pkg::ST_REC_CHK:
				if (crd_t_q == 0 || ci_q == (CW+1)'(CACHE_DEPTH - 1)) state_d = lpct_pkg::ST_IDLE;
				else state_d = lpct_pkg::ST_REC_RD;
			lpct_pkg::ST_AGE_RD: state_d = lpct_pkg::ST_AGE_CHK;
			lpct_pkg::ST_AGE_CHK:
				if (age <= {16'd0, lifetime_q} && crd_t_q != 0) state_d = lpct_pkg::ST_SL_RD;
				else if (ci_q == (CW+1)'(CACHE_DEPTH - 1)) state_d = lpct_pkg::ST_RK_RD;
				else state_d = lpct_pkg::ST_AGE_RD;
			lpct_pkg::ST_SL_RD: state_d = lpct_pkg::ST_SL_CHK;
			lpct_pkg::ST_SL_CHK:
				if (srd_n_q == 0) state_d = lpct_pkg::ST_SL_WR;
				else state_d = lpct_pkg::ST_SL_MUL;
			lpct_pkg::ST_SL_MUL: state_d = lpct_pkg::ST_SL_CMP;
			lpct_pkg::ST_SL_CMP:
				if (d2 < {11'd0, r2_q}) state_d = lpct_pkg::ST_DIV;
				else if (si_q == (SW+1)'(SLOT_COUNT - 1))
					state_d = (ci_q == (CW+1)'(CACHE_DEPTH - 1)) ? lpct_pkg::ST_RK_RD
						: lpct_pkg::ST_AGE_RD;
				else state_d = lpct_pkg::ST_SL_RD;
			lpct_pkg::ST_DIV: if (div_done && div_y_q) state_d = lpct_pkg::ST_SL_WR;
			lpct_pkg::ST_SL_WR:
				state_d = (ci_q == (CW+1)'(CACHE_DEPTH - 1)) ? lpct_pkg::ST_RK_RD
					: lpct_pkg::ST_AGE_RD;
			lpct_pkg::ST_RK_RD: state_d = lpct_pkg::ST_RK_CHK;
			lpct_pkg::ST_RK_CHK:
				if (si_q == (SW+1)'(SLOT_COUNT - 1)) state_d = lpct_pkg::ST_OUT_RD;
				else state_d = lpct_pkg::ST_RK_RD;
			lpct_pkg::ST_OUT_RD: if (!ovalid_q || out_ch.ready) state_d = lpct_pkg::ST_OUT_SEND;
			lpct_pkg::ST_OUT_SEND:
				if (k_q == 2'd2) state_d = lpct_pkg::ST_IDLE;
				else state_d = lpct_pkg::ST_OUT_RD;
			default: state_d = lpct_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and writeback values.
	logic join_q;
	always_comb begin
		c_we = 1'b0; c_wt = cmd_q.sample_time_ms;
		c_wx = cmd_q.point_x; c_wy = cmd_q.point_y;
		s_we = 1'b0; s_wn = '0; s_wt = srd_t_q; s_wx = srd_x_q; s_wy = srd_y_q;
		div_start = 1'b0;
		if (clr_busy_q) begin
			c_we = 1'b1; c_wt = '0;
			s_we = 1'b1;
		end
		case (state_q)
			lpct_pkg::ST_CLR_CMD: s_we = 1'b1;
			lpct_pkg::ST_REC_CHK: c_we = (crd_t_q == 0);
			lpct_pkg::ST_AGE_CHK: if (age > {16'd0, lifetime_q}) begin
				c_we = 1'b1; c_wt = '0;
			end
			lpct_pkg::ST_SL_MUL: div_start = 1'b0;
			lpct_pkg::ST_SL_CMP: div_start = (d2 < {11'd0, r2_q});
			lpct_pkg::ST_DIV: div_start = div_done && !div_y_q;
			lpct_pkg::ST_SL_WR: begin
				s_we = 1'b1;
				if (join_q) begin
					s_wn = (srd_n_q < lpct_pkg::COUNT_MAX) ? srd_n_q + 9'd1 : srd_n_q;
					s_wt = (srd_t_q < crd_t_q) ? crd_t_q : srd_t_q;
					s_wx = mx_q; s_wy = div_quo;
				end else begin
					s_wn = 9'd1; s_wt = crd_t_q; s_wx = crd_x_q; s_wy = crd_y_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpct_pkg::ST_IDLE;
			clr_busy_q <= 1'b1;
			ci_q <= '0;
			si_q <= '0;
			now_q <= '0;
			ovalid_q <= 1'b0;
			k_q <= '0;
			div_y_q <= 1'b0;
			join_q <= 1'b0;
		end else begin
			state_q <= clr_busy_q ? lpct_pkg::ST_IDLE : state_d;
			if (state_q == lpct_pkg::ST_OUT_SEND) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			if (clr_busy_q) begin
				// The pass lasts until both the cache and the slots have been swept.
				if (ci_q >= (CW+1)'(CACHE_DEPTH - 1) && si_q >= (SW+1)'(SLOT_COUNT - 1)) begin
					clr_busy_q <= 1'b0; ci_q <= '0; si_q <= '0;
				end else begin
					if (ci_q < (CW+1)'(CACHE_DEPTH - 1)) ci_q <= ci_q + 1'b1;
					if (si_q < (SW+1)'(SLOT_COUNT - 1)) si_q <= si_q + 1'b1;
				end
			end else begin
				case (state_q)
					lpct_pkg::ST_IDLE: if (acc) begin
						ci_q <= '0; si_q <= '0;
						if (in_ch.data.command == lpct_pkg::CMD_RECORD)
							now_q <= in_ch.data.sample_time_ms;
					end
					lpct_pkg::ST_CLR_CMD: si_q <= si_q + 1'b1;
					lpct_pkg::ST_REC_CHK:
						if (crd_t_q != 0) ci_q <= ci_q + 1'b1;
					lpct_pkg::ST_AGE_CHK: begin
						si_q <= '0;
						if (state_d != lpct_pkg::ST_SL_RD) ci_q <= ci_q + 1'b1;
						bn_q[0] <= '0; bn_q[1] <= '0; bn_q[2] <= '0;
						bp_q[0] <= '0; bp_q[1] <= '0; bp_q[2] <= '0;
					end
					lpct_pkg::ST_SL_CHK: join_q <= srd_n_q != 0;
					lpct_pkg::ST_SL_CMP: begin
						div_y_q <= 1'b0;
						if (state_d == lpct_pkg::ST_SL_RD) si_q <= si_q + 1'b1;
						else if (state_d == lpct_pkg::ST_RK_RD) si_q <= '0;
						if (state_d == lpct_pkg::ST_AGE_RD || state_d == lpct_pkg::ST_RK_RD)
							ci_q <= ci_q + 1'b1;
					end
					lpct_pkg::ST_DIV: if (div_done) begin
						div_y_q <= 1'b1;
						if (!div_y_q) mx_q <= div_quo;
					end
					lpct_pkg::ST_SL_WR: begin
						ci_q <= ci_q + 1'b1;
						si_q <= '0;
					end
					lpct_pkg::ST_RK_RD: if (ci_q != 0) begin
						ci_q <= '0; si_q <= '0;
					end
					lpct_pkg::ST_RK_CHK: begin
						if (srd_n_q > bn_q[0]) begin
							bn_q[2] <= bn_q[1]; bp_q[2] <= bp_q[1];
							bn_q[1] <= bn_q[0]; bp_q[1] <= bp_q[0];
							bn_q[0] <= srd_n_q; bp_q[0] <= si;
						end else if (srd_n_q > bn_q[1]) begin
							bn_q[2] <= bn_q[1]; bp_q[2] <= bp_q[1];
							bn_q[1] <= srd_n_q; bp_q[1] <= si;
						end else if (srd_n_q > bn_q[2]) begin
							bn_q[2] <= srd_n_q; bp_q[2] <= si;
						end
						if (state_d == lpct_pkg::ST_OUT_RD) begin
							k_q <= '0;
							si_q <= (srd_n_q > bn_q[0]) ? {1'b0, si} : {1'b0, bp_q[0]};
						end else si_q <= si_q + 1'b1;
					end
					lpct_pkg::ST_OUT_SEND: begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd0) si_q <= {1'b0, bp_q[1]};
						else si_q <= {1'b0, bp_q[2]};
					end
					default: ;
				endcase
			end
		end
	end

	// The first rank index is only final after the last compare; it is
	// forwarded above. The slot read in ST_OUT_RD lands for ST_OUT_SEND.
	logic [1:0] lim;
	logic [8:0] q;
	assign lim = (report_q == 2'd0) ? 2'd1 : report_q;
	assign q = (k_q >= lim) ? 9'd0 : srd_n_q;

	always_ff @(posedge clk) begin
		if (state_q == lpct_pkg::ST_IDLE && acc) cmd_q <= in_ch.data;
		r2_q <= radius_q * radius_q;
		if (state_q == lpct_pkg::ST_SL_CHK) begin
			dx_q <= 17'(srd_x_q) - 17'($signed(crd_x_q));
			dy_q <= 17'(srd_y_q) - 17'($signed(crd_y_q));
		end
		if (state_q == lpct_pkg::ST_SL_MUL) begin
			sqx_q <= 34'(dx_q * dx_q);
			sqy_q <= 34'(dy_q * dy_q);
		end
		if (state_q == lpct_pkg::ST_OUT_SEND) begin
			obuf_q.rank <= k_q;
			obuf_q.last <= k_q == 2'd2;
			if (q > qthr_q) begin
				obuf_q.present <= 1'b1; obuf_q.quality <= q;
				obuf_q.seen_time_ms <= srd_t_q;
				obuf_q.centre_x <= srd_x_q; obuf_q.centre_y <= srd_y_q;
			end else begin
				obuf_q.present <= 1'b0; obuf_q.quality <= '0;
				obuf_q.seen_time_ms <= '0;
				obuf_q.centre_x <= lpct_pkg::ABSENT_X; obuf_q.centre_y <= '0;
			end
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = obuf_q;
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the lidar point cluster block with a built-in cluster predictor.
`timescale 1ns / 1ps

module tb_top;
	localparam int CACHE_N = 256;
	localparam int SLOTS_N = 16;
	localparam int LIMIT_CYCLES = 5000000;
	localparam int SETTLE_CYCLES = 700;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic clk;
	logic arst_n;

	lpct_in_if in_ch();
	lpct_out_if out_ch();
	lpct_cfg_if cfg();

	lidar_point_cluster_top3_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg(cfg.sink)
	);

	// Predictor state and configuration.
	logic [15:0] cfg_lifetime;
	logic [11:0] cfg_radius;
	logic [1:0] cfg_report;
	logic [8:0] cfg_quality;
	logic [31:0] now_ms;
	logic [31:0] pt_time [CACHE_N];
	int pt_x [CACHE_N];
	int pt_y [CACHE_N];
	int unsigned cl_count [SLOTS_N];
	logic [31:0] cl_time [SLOTS_N];
	int cl_x [SLOTS_N];
	int cl_y [SLOTS_N];

	lpct_pkg::in_item_t pending_points [$];
	lpct_pkg::out_item_t expected_detections [$];

	int send_idle;
	int recv_stall;
	bit in_fire;
	bit cfg_fire;
	bit failed;
	int unsigned cycles;
	logic [31:0] cur_time;

	function automatic int running_mean(int point, int centre, int unsigned n);
		longint num;
		num = longint'(point) + longint'(n) * longint'(centre);
		return int'(num / (longint'(n) + 1));
	endfunction

	function automatic void place_point(logic [31:0] t, int x, int y);
		longint r2;
		longint dx;
		longint dy;
		int unsigned n;
		r2 = longint'(cfg_radius) * longint'(cfg_radius);
		for (int i = 0; i < SLOTS_N; i++) begin
			if (cl_count[i] == 0) begin
				cl_count[i] = 1;
				cl_time[i] = t;
				cl_x[i] = x;
				cl_y[i] = y;
				return;
			end
			dx = longint'(cl_x[i]) - x;
			dy = longint'(cl_y[i]) - y;
			if (dx * dx + dy * dy < r2) begin
				n = cl_count[i];
				if (n < 511) cl_count[i] = n + 1;
				if (cl_time[i] < t) cl_time[i] = t;
				cl_x[i] = running_mean(x, cl_x[i], n);
				cl_y[i] = running_mean(y, cl_y[i], n);
				return;
			end
		end
	endfunction

	function automatic void predict_update();
		int unsigned best_n [3];
		int best_p [3];
		int unsigned lim;
		int unsigned q;
		logic [31:0] age;
		lpct_pkg::out_item_t d;
		lim = (cfg_report == 0) ? 1 : cfg_report;
		for (int k = 0; k < 3; k++) begin
			best_n[k] = 0;
			best_p[k] = 0;
		end
		for (int j = 0; j < CACHE_N; j++) begin
			age = now_ms - pt_time[j];
			if (age > cfg_lifetime) pt_time[j] = '0;
			else if (pt_time[j] != 0) place_point(pt_time[j], pt_x[j], pt_y[j]);
		end
		for (int j = 0; j < SLOTS_N; j++) begin
			if (cl_count[j] > best_n[0]) begin
				best_n[2] = best_n[1]; best_p[2] = best_p[1];
				best_n[1] = best_n[0]; best_p[1] = best_p[0];
				best_n[0] = cl_count[j]; best_p[0] = j;
			end else if (cl_count[j] > best_n[1]) begin
				best_n[2] = best_n[1]; best_p[2] = best_p[1];
				best_n[1] = cl_count[j]; best_p[1] = j;
			end else if (cl_count[j] > best_n[2]) begin
				best_n[2] = cl_count[j]; best_p[2] = j;
			end
		end
		for (int k = 0; k < 3; k++) begin
			q = (k >= lim) ? 0 : cl_count[best_p[k]];
			d.rank = k[1:0];
			d.last = (k == 2);
			if (q > cfg_quality) begin
				d.present = 1'b1;
				d.quality = q[8:0];
				d.seen_time_ms = cl_time[best_p[k]];
				d.centre_x = cl_x[best_p[k]][15:0];
				d.centre_y = cl_y[best_p[k]][15:0];
			end else begin
				d.present = 1'b0;
				d.quality = '0;
				d.seen_time_ms = '0;
				d.centre_x = lpct_pkg::ABSENT_X;
				d.centre_y = '0;
			end
			expected_detections.push_back(d);
		end
	endfunction

	function automatic void predict_command(lpct_pkg::in_item_t it);
		case (it.command)
			lpct_pkg::CMD_RECORD: begin
				now_ms = it.sample_time_ms;
				for (int j = 0; j < CACHE_N; j++) begin
					if (pt_time[j] == 0) begin
						pt_time[j] = it.sample_time_ms;
						pt_x[j] = it.point_x;
						pt_y[j] = it.point_y;
						break;
					end
				end
			end
			lpct_pkg::CMD_UPDATE: predict_update();
			lpct_pkg::CMD_CLEAR: begin
				for (int i = 0; i < SLOTS_N; i++) cl_count[i] = 0;
			end
			default: ;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL lidar_point_cluster_top3_top");
			$finish;
		end
	end

	// Transaction monitor: acceptance, prediction and result checking.
	always @(posedge clk) begin
		lpct_pkg::out_item_t e;
		lpct_pkg::out_item_t a;
		in_fire <= in_ch.valid && in_ch.ready;
		cfg_fire <= cfg.valid && cfg.ready;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index[1:0])
					lpct_pkg::REG_LIFETIME: cfg_lifetime = cfg.data.data;
					lpct_pkg::REG_RADIUS: cfg_radius = cfg.data.data[11:0];
					lpct_pkg::REG_REPORT: cfg_report = cfg.data.data[1:0];
					lpct_pkg::REG_QUALITY: cfg_quality = cfg.data.data[8:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) predict_command(in_ch.data);
			if (out_ch.valid && out_ch.ready) begin
				a = out_ch.data;
				if (expected_detections.size() == 0) begin
					$error("unexpected detection transaction: %p", a);
					failed = 1'b1;
				end else begin
					e = expected_detections.pop_front();
					if (a.rank !== e.rank) begin
						$error("rank: expected %0d, got %0d", e.rank, a.rank); failed = 1'b1;
					end
					if (a.present !== e.present) begin
						$error("present: expected %0d, got %0d", e.present, a.present);
						failed = 1'b1;
					end
					if (a.quality !== e.quality) begin
						$error("quality: expected %0d, got %0d", e.quality, a.quality);
						failed = 1'b1;
					end
					if (a.seen_time_ms !== e.seen_time_ms) begin
						$error("seen_time_ms: expected %0d, got %0d", e.seen_time_ms,
							a.seen_time_ms);
						failed = 1'b1;
					end
					if (a.centre_x !== e.centre_x) begin
						$error("centre_x: expected %0d, got %0d", e.centre_x, a.centre_x);
						failed = 1'b1;
					end
					if (a.centre_y !== e.centre_y) begin
						$error("centre_y: expected %0d, got %0d", e.centre_y, a.centre_y);
						failed = 1'b1;
					end
					if (a.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, a.last); failed = 1'b1;
					end
				end
			end
		end
	end

	// Driver: inputs change on the falling edge only.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_fire) begin
				if (pending_points.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_ch.data <= pending_points.pop_front();
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic push_cmd(logic [1:0] c, logic [31:0] t, logic [15:0] x, logic [15:0] y);
		lpct_pkg::in_item_t it;
		it.command = c;
		it.sample_time_ms = t;
		it.point_x = x;
		it.point_y = y;
		pending_points.push_back(it);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg.data.index = {1'b0, idx};
		cfg.data.data = val;
		cfg.valid = 1'b1;
		do @(negedge clk); while (!cfg_fire);
		cfg.valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_points.size() != 0 || in_ch.valid || expected_detections.size() != 0)
			@(posedge clk);
		// A record or clear may still be running after the last detection.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int life, int rad, int rep, int qual, int idle, int stall);
		write_reg(lpct_pkg::REG_LIFETIME, life[15:0]);
		write_reg(lpct_pkg::REG_RADIUS, rad[15:0]);
		write_reg(lpct_pkg::REG_REPORT, rep[15:0]);
		write_reg(lpct_pkg::REG_QUALITY, qual[15:0]);
		send_idle = idle;
		recv_stall = stall;
	endtask

	// Bursts of nearby records followed by an update, sometimes a clear or unknown command, with some noise.
	task automatic random_bursts(int n_items);
		int made;
		int cx;
		int cy;
		int burst;
		int spread;
		made = 0;
		while (made < n_items) begin
			burst = $urandom_range(1, 10);
			cx = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 65535)) - 32768
				: int'($urandom_range(0, 4000)) - 2000;
			cy = int'($urandom_range(0, 4000)) - 2000;
			spread = $urandom_range(0, 3) == 0 ? 3000 : 150;
			for (int b = 0; b < burst; b++) begin
				case ($urandom_range(0, 9))
					0: cur_time = $urandom;
					1, 2: cur_time = cur_time + cfg_lifetime + $urandom_range(1, 50);
					default: cur_time = cur_time + $urandom_range(0, cfg_lifetime / 4 + 2);
				endcase
				if ($urandom_range(0, 19) == 0)
					push_cmd(lpct_pkg::CMD_RECORD, cur_time, 16'($urandom), 16'($urandom));
				else
					push_cmd(lpct_pkg::CMD_RECORD, cur_time,
						16'(cx + int'($urandom_range(0, 2 * spread)) - spread),
						16'(cy + int'($urandom_range(0, 2 * spread)) - spread));
				made++;
			end
			push_cmd(lpct_pkg::CMD_UPDATE, $urandom, 16'($urandom), 16'($urandom));
			made++;
			case ($urandom_range(0, 9))
				0: begin
					push_cmd(lpct_pkg::CMD_CLEAR, $urandom, 16'($urandom), 16'($urandom));
					made++;
				end
				1: push_cmd(CMD_UNKNOWN, $urandom, 16'($urandom), 16'($urandom));
				default: ;
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		failed = 1'b0;
		cycles = 0;
		in_fire = 1'b0;
		cfg_fire = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		cfg_lifetime = 16'd500;
		cfg_radius = 12'd200;
		cfg_report = 2'd3;
		cfg_quality = 9'd1;
		now_ms = '0;
		for (int j = 0; j < CACHE_N; j++) begin
			pt_time[j] = '0; pt_x[j] = 0; pt_y[j] = 0;
		end
		for (int i = 0; i < SLOTS_N; i++) begin
			cl_count[i] = 0; cl_time[i] = '0; cl_x[i] = 0; cl_y[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, time zero, wrap of the age, every command.
		push_cmd(lpct_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd0, 16'h7fff, 16'h8000);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd100, 16'h8000, 16'h7fff);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd120, 16'h8000, 16'h7fff);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd130, 16'h7fff, 16'h7fff);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd140, 16'h0000, 16'hffff);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd150, 16'h0010, 16'hfff0);
		push_cmd(lpct_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
		push_cmd(CMD_UNKNOWN, 32'hffffffff, 16'hffff, 16'hffff);
		push_cmd(lpct_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
		push_cmd(lpct_pkg::CMD_CLEAR, 32'd0, 16'd0, 16'd0);
		push_cmd(lpct_pkg::CMD_RECORD, 32'hfffffff0, 16'd5, 16'd5);
		push_cmd(lpct_pkg::CMD_RECORD, 32'hfffffffe, 16'd7, 16'd3);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd20, 16'd9, 16'd1);
		push_cmd(lpct_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
		push_cmd(lpct_pkg::CMD_RECORD, 32'd5000, 16'hfc18, 16'd0);
		push_cmd(lpct_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
		push_cmd(lpct_pkg::CMD_CLEAR, 32'd0, 16'd0, 16'd0);
		push_cmd(lpct_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
		cur_time = 32'd6000;
		drain();

		configure(500, 200, 3, 1, 0, 0);
		random_bursts(10);
		drain();

		configure(0, 1, 1, 0, 81, 0);
		random_bursts(10);
		drain();

		// Fill the cache past its depth, then saturate the slot counts.
		configure(65535, 4095, 2, 256, 0, 81);
		push_cmd(lpct_pkg::CMD_CLEAR, 32'd0, 16'd0, 16'd0);
		cur_time = cur_time + 1;
		for (int j = 0; j < CACHE_N + 1; j++)
			push_cmd(lpct_pkg::CMD_RECORD, cur_time + j[31:0], 16'($urandom_range(0, 400)),
				16'($urandom_range(0, 400)));
		repeat (3) push_cmd(lpct_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
		cur_time = cur_time + 32'd100000;
		drain();

		configure(2000, 300, 0, 2, 15, 15);
		random_bursts(10);
		drain();

		if (!failed) begin
			$display("PASS lidar_point_cluster_top3_top");
		end else begin
			$display("FAIL lidar_point_cluster_top3_top");
		end
		$finish;
	end
endmodule
